// ----- hdl/gvc_pkg.sv -----
package gvc_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int VTX_W        = 8;
    localparam int VTX_AW       = $clog2(MAX_VERTICES);
    localparam int COLOR_W      = 8;
    localparam int NUM_COLORS   = 256;
    localparam int USED_W       = 9;
    localparam int GRP_W        = 32;
    localparam int NUM_GRP      = NUM_COLORS / GRP_W;
    localparam int GRP_AW       = $clog2(GRP_W);

    typedef logic [VTX_W-1:0]   vtx_t;
    typedef logic [COLOR_W-1:0] color_t;

    // Summary of one 32-bit slice of the used-color map.
    typedef struct packed {
        logic              full;
        logic [GRP_AW-1:0] ffz;
    } grp_sum_t;

    typedef grp_sum_t [NUM_GRP-1:0] map_sum_t;

    // Control from the neighbor stage to the used-color map.
    typedef struct packed {
        logic   adv;
        logic   clr;
        logic   last;
        logic   set_en;
        color_t set_color;
    } map_ctl_t;

    function automatic logic in_range(input vtx_t v);
        return (32'(v) < 32'(MAX_VERTICES));
    endfunction

    function automatic grp_sum_t first_zero(input logic [GRP_W-1:0] w);
        grp_sum_t s;
        s.full = &w;
        s.ffz  = '0;
        for (int i = GRP_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                s.ffz = GRP_AW'(i);
            end
        end
        return s;
    endfunction

    // Lowest free color from the slice summaries; saturates when all are used.
    function automatic color_t pick_color(input map_sum_t sums);
        color_t c;
        c = color_t'(NUM_COLORS - 1);
        for (int g = NUM_GRP - 1; g >= 0; g--) begin
            if (!sums[g].full) begin
                c = color_t'(g * GRP_W + int'(sums[g].ffz));
            end
        end
        return c;
    endfunction

endpackage

// ----- hdl/greedy_vertex_coloring.sv -----
// Channel   Dir  Signals                     Contents
// s_axis    in   tdata[15:0] tuser[1:0] tlast  one neighbor item of the vertex being colored
// m_axis    out  tdata[31:0]                 vertex, chosen color, colors used so far
//
// Rate: one item per cycle while s_axis_tready is high; m_axis_tvalid rises when
// the item flagged last has left the commit stage for the output register. The rate
// is set by one read of the color RAM and one update of the used-color map per item.
// Reset: colored marks and the used-color map clear at once; the color RAM is
// not cleared, so items are taken from the first cycle after reset.
// Stalls: s_axis_tready falls only while a finished result waits on m_axis and
// the next result is already waiting behind it.
module greedy_vertex_coloring
    import gvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // vertex[7:0], neighbor[15:8]
    input  logic [1:0]  s_axis_tuser,   // new_run[0], neighbor_valid[1]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // colored_vertex[7:0], color[15:8], colors_used[24:16]
);

    // Neighbor stage: the item whose color-RAM read is returning.
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_new_run_reg;
    logic        s1_last_reg;
    logic        s1_nvalid_reg;
    vtx_t        s1_vertex_reg;
    vtx_t        s1_nbr_reg;

    // Commit stage: the item that picks its color and updates the tables.
    logic        s2_valid_reg, s2_valid_next;
    logic        s2_new_run_reg;
    logic        s2_last_reg;
    vtx_t        s2_vertex_reg;
    map_sum_t    s2_sum_reg;

    // Copy of the last color-RAM write, covering a read issued on the same edge.
    logic        wb_valid_reg, wb_valid_next;
    vtx_t        wb_addr_reg;
    color_t      wb_color_reg;

    logic [MAX_VERTICES-1:0] mark_reg, mark_next;
    color_t      highest_reg, highest_next;

    logic        out_valid_reg, out_valid_next;
    vtx_t        out_vertex_reg;
    color_t      out_color_reg;
    logic [USED_W-1:0] out_used_reg;

    logic        in_accept;
    logic        s1_adv;
    logic        s2_adv;
    logic        s2_free;
    logic        wr_en;
    color_t      ram_rdata;
    color_t      s2_color;
    color_t      hi_base;
    color_t      hi_new;
    logic        fwd_hit;
    logic        mark_now;
    color_t      nbr_color;
    map_ctl_t    map_ctl;
    map_sum_t    map_sums;

    // ---------------------------------------------------------------
    // Flow control. The output register frees the commit stage as soon
    // as the consumer takes the waiting result.
    // ---------------------------------------------------------------
    assign s2_adv    = s2_valid_reg && (!s2_last_reg || !out_valid_reg || m_axis_tready);
    assign s2_free   = !s2_valid_reg || s2_adv;
    assign s1_adv    = s1_valid_reg && s2_free;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Color of each vertex lives in a RAM; it is read by neighbor address as
    // the item is accepted and written when a vertex commits its color.
    assign wr_en = s2_adv && s2_last_reg && in_range(s2_vertex_reg);

    gvc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_VERTICES)
    ) u_color_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s2_vertex_reg[VTX_AW-1:0]),
        .wdata (s2_color),
        .re    (in_accept),
        .raddr (s_axis_tdata[8 +: VTX_AW]),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Commit stage: lowest free color and the running maximum.
    // ---------------------------------------------------------------
    assign s2_color = pick_color(s2_sum_reg);
    assign hi_base  = s2_new_run_reg ? '0 : highest_reg;
    assign hi_new   = (s2_color > hi_base) ? s2_color : hi_base;

    // ---------------------------------------------------------------
    // Neighbor stage. The vertex in the commit stage has not written its
    // mark or color yet, so a neighbor that matches it takes both from
    // there. A new run in the commit stage hides every older mark.
    // ---------------------------------------------------------------
    always_comb
    begin
        fwd_hit = s2_valid_reg && s2_last_reg && in_range(s2_vertex_reg)
                  && (s2_vertex_reg == s1_nbr_reg);
        if (s1_new_run_reg)
        begin
            mark_now = 1'b0;
        end
        else if (fwd_hit)
        begin
            mark_now = 1'b1;
        end
        else if (s2_valid_reg && s2_new_run_reg)
        begin
            mark_now = 1'b0;
        end
        else
        begin
            mark_now = mark_reg[s1_nbr_reg[VTX_AW-1:0]];
        end

        if (fwd_hit)
        begin
            nbr_color = s2_color;
        end
        else if (wb_valid_reg && (wb_addr_reg == s1_nbr_reg))
        begin
            nbr_color = wb_color_reg;
        end
        else
        begin
            nbr_color = ram_rdata;
        end

        map_ctl.adv       = s1_adv;
        map_ctl.clr       = s1_new_run_reg;
        map_ctl.last      = s1_last_reg;
        map_ctl.set_en    = s1_valid_reg && s1_nvalid_reg && in_range(s1_nbr_reg) && mark_now;
        map_ctl.set_color = nbr_color;
    end

    gvc_color_map u_color_map (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (map_ctl),
        .sums  (map_sums)
    );

    // ---------------------------------------------------------------
    // Next-state logic for control registers.
    // ---------------------------------------------------------------
    always_comb
    begin
        s1_valid_next  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
        wb_valid_next  = wb_valid_reg || wr_en;
        out_valid_next = out_valid_reg && !m_axis_tready;
        mark_next      = mark_reg;
        highest_next   = highest_reg;
        if (s2_adv)
        begin
            if (s2_new_run_reg)
            begin
                mark_next = '0;
            end
            if (wr_en)
            begin
                mark_next[s2_vertex_reg[VTX_AW-1:0]] = 1'b1;
            end
            highest_next = s2_last_reg ? hi_new : hi_base;
            if (s2_last_reg)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mark_reg      <= '0;
            highest_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            wb_valid_reg  <= wb_valid_next;
            out_valid_reg <= out_valid_next;
            mark_reg      <= mark_next;
            highest_reg   <= highest_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_new_run_reg <= s_axis_tuser[0];
            s1_nvalid_reg  <= s_axis_tuser[1];
            s1_last_reg    <= s_axis_tlast;
            s1_vertex_reg  <= s_axis_tdata[7:0];
            s1_nbr_reg     <= s_axis_tdata[15:8];
        end
        if (s1_adv)
        begin
            s2_new_run_reg <= s1_new_run_reg;
            s2_last_reg    <= s1_last_reg;
            s2_vertex_reg  <= s1_vertex_reg;
            s2_sum_reg     <= map_sums;
        end
        if (wr_en)
        begin
            wb_addr_reg  <= s2_vertex_reg;
            wb_color_reg <= s2_color;
        end
        if (s2_adv && s2_last_reg)
        begin
            out_vertex_reg <= s2_vertex_reg;
            out_color_reg  <= s2_color;
            out_used_reg   <= USED_W'(hi_new) + USED_W'(1);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_used_reg, out_color_reg, out_vertex_reg};

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_last_reg && out_valid_reg && !m_axis_tready |-> !s2_adv)
        else $error("commit stage overwrote a result still waiting on the output");

    a_mark_set: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> mark_reg[$past(s2_vertex_reg[VTX_AW-1:0])])
        else $error("committed vertex is not marked colored");

    a_color_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ({1'b0, out_color_reg} < out_used_reg))
        else $error("reported color is not below the color count");

endmodule

// ----- hdl/gvc_ram.sv -----
module gvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read returns the old contents when the same entry is written.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/gvc_color_map.sv -----
module gvc_color_map
    import gvc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  map_ctl_t ctl,
    output map_sum_t sums
);

    logic [NUM_COLORS-1:0] map_reg;
    logic [NUM_COLORS-1:0] map_next;
    logic [NUM_COLORS-1:0] map_eff;

    // The current neighbor's color is folded in before the summary is taken.
    always_comb
    begin
        map_eff = ctl.clr ? '0 : map_reg;
        if (ctl.set_en)
        begin
            map_eff[ctl.set_color] = 1'b1;
        end
        map_next = map_reg;
        if (ctl.adv)
        begin
            map_next = ctl.last ? '0 : map_eff;
        end
    end

    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            sums[g] = first_zero(map_eff[g*GRP_W +: GRP_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else
        begin
            map_reg <= map_next;
        end
    end

endmodule

// ----- bench/greedy_vertex_coloring_test.sv -----
module greedy_vertex_coloring_test
    import gvc_pkg::*;
();

    // Bounds of the run. About 800 items in all; the watchdog limit sits well above
    // what a run needs, even with the longest gaps and stalls on every item.
    localparam int LIMIT_CYCLES = 500_000;
    localparam int RANDOM_ITEMS = 550;
    localparam int CLIQUE_SIZE  = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int SHOWN_ERRORS = 10;

    // One coloring result as it leaves m_axis.
    typedef struct packed {
        vtx_t              vtx;
        color_t            color;
        logic [USED_W-1:0] used;
    } coloring_t;

    // Tracks the coloring of the current run and the colorings still owed by the block.
    class coloring_scoreboard;
        color_t    stored_color [MAX_VERTICES];
        bit        is_colored   [MAX_VERTICES];
        bit        color_taken  [NUM_COLORS];
        color_t    top_color;
        coloring_t awaited [$];
        int        errors;

        function new();
            foreach (is_colored[i])
            begin
                is_colored[i] = 1'b0;
            end
            foreach (color_taken[i])
            begin
                color_taken[i] = 1'b0;
            end
            top_color = '0;
            errors    = 0;
        endfunction

        // Called for every item accepted on s_axis.
        function void note_item(bit new_run, vtx_t vtx, vtx_t nbr, bit nbr_ok, bit last_nbr);
            int        pick;
            coloring_t c;
            if (new_run)
            begin
                foreach (is_colored[i])
                begin
                    is_colored[i] = 1'b0;
                end
                foreach (color_taken[i])
                begin
                    color_taken[i] = 1'b0;
                end
                top_color = '0;
            end
            if (nbr_ok && 32'(nbr) < MAX_VERTICES && is_colored[nbr])
            begin
                color_taken[stored_color[nbr]] = 1'b1;
            end
            if (!last_nbr)
            begin
                return;
            end
            // Lowest free color; stays at the top color when every color is taken.
            pick = NUM_COLORS - 1;
            for (int k = NUM_COLORS - 1; k >= 0; k--)
            begin
                if (!color_taken[k])
                begin
                    pick = k;
                end
            end
            if (32'(vtx) < MAX_VERTICES)
            begin
                stored_color[vtx] = color_t'(pick);
                is_colored[vtx]   = 1'b1;
            end
            if (pick > int'(top_color))
            begin
                top_color = color_t'(pick);
            end
            foreach (color_taken[i])
            begin
                color_taken[i] = 1'b0;
            end
            c.vtx   = vtx;
            c.color = color_t'(pick);
            c.used  = USED_W'(top_color) + 1'b1;
            awaited.push_back(c);
        endfunction

        function void flag(string what, coloring_t want, coloring_t got);
            errors++;
            if (errors <= SHOWN_ERRORS)
            begin
                $display("mismatch (%s): expected vertex %0d color %0d used %0d,",
                         what, want.vtx, want.color, want.used);
                $display("    got vertex %0d color %0d used %0d",
                         got.vtx, got.color, got.used);
            end
        endfunction

        // Called for every item accepted on m_axis.
        function void check_result(logic [31:0] data);
            coloring_t got;
            coloring_t want;
            string     bad;
            got.vtx   = data[7:0];
            got.color = data[15:8];
            got.used  = data[24:16];
            if (awaited.size() == 0)
            begin
                flag("no coloring pending", '0, got);
                return;
            end
            want = awaited.pop_front();
            bad  = "";
            if (got.vtx !== want.vtx)
            begin
                bad = {bad, " vertex"};
            end
            if (got.color !== want.color)
            begin
                bad = {bad, " color"};
            end
            if (got.used !== want.used)
            begin
                bad = {bad, " colors_used"};
            end
            if (bad != "")
            begin
                flag({"wrong", bad}, want, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // vertex[7:0], neighbor[15:8]
    logic [1:0]  s_axis_tuser;   // new_run[0], neighbor_valid[1]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // colored_vertex[7:0], color[15:8], colors_used[24:16]

    coloring_scoreboard sb;
    int                 items_sent;
    int                 steady_items;
    int                 cycle_count;
    bit                 hold_request;

    greedy_vertex_coloring dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 88)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // The sender now and then runs a stretch of items back to back.
    function automatic int next_send_gap();
        if (steady_items > 0)
        begin
            steady_items--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            steady_items = $urandom_range(20, 60);
        end
        return idle_length();
    endfunction

    // Offers one neighbor item and waits until the block takes it. The
    // scoreboard is updated at the edge where the item is accepted.
    task automatic send_neighbor(bit new_run, vtx_t vtx, vtx_t nbr, bit nbr_ok, bit last_nbr);
        int gap;
        gap = next_send_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {nbr, vtx};
        s_axis_tuser  <= {nbr_ok, new_run};
        s_axis_tlast  <= last_nbr;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sb.note_item(new_run, vtx, nbr, nbr_ok, last_nbr);
        items_sent++;
    endtask

    // Hand-picked items: lone vertices at both ends of the index range, a
    // small chain of rising colors, a vertex that lists itself and gets
    // recolored, an ignored neighbor, an uncolored neighbor, a repeated
    // neighbor, and a new run arriving mid-vertex and together with last.
    task automatic run_directed();
        send_neighbor(1'b1, 8'd0,   8'd0,   1'b0, 1'b1);
        send_neighbor(1'b0, 8'd255, 8'd255, 1'b0, 1'b1);
        send_neighbor(1'b0, 8'd1,   8'd0,   1'b1, 1'b1);
        send_neighbor(1'b0, 8'd2,   8'd0,   1'b1, 1'b0);
        send_neighbor(1'b0, 8'd2,   8'd1,   1'b1, 1'b1);
        send_neighbor(1'b0, 8'd255, 8'd255, 1'b1, 1'b1);
        send_neighbor(1'b0, 8'd128, 8'd1,   1'b0, 1'b0);
        send_neighbor(1'b0, 8'd128, 8'd200, 1'b1, 1'b0);
        send_neighbor(1'b0, 8'd128, 8'd255, 1'b1, 1'b1);
        send_neighbor(1'b0, 8'd3,   8'd0,   1'b1, 1'b0);
        send_neighbor(1'b0, 8'd3,   8'd0,   1'b1, 1'b0);
        send_neighbor(1'b0, 8'd3,   8'd2,   1'b1, 1'b1);
        send_neighbor(1'b0, 8'd170, 8'd2,   1'b1, 1'b0);
        send_neighbor(1'b1, 8'd170, 8'd2,   1'b1, 1'b1);
        send_neighbor(1'b1, 8'd85,  8'd170, 1'b1, 1'b1);
        send_neighbor(1'b0, 8'd84,  8'd85,  1'b1, 1'b1);
    endtask

    // One vertex with a random neighbor list. Vertices and neighbors come
    // mostly from a small pool at the bottom or top of the index range, so
    // that neighbors are often colored and vertices get recolored. A few
    // items are noise: neighbor_valid low, a vertex that changes midway, or
    // a new run in the middle of a list.
    task automatic color_random_vertex();
        vtx_t vtx;
        vtx_t nbr;
        bit   fresh;
        bit   ok;
        int   count;
        int   base;
        int   r;
        base  = ($urandom_range(0, 1) == 0) ? 0 : 240;
        vtx   = ($urandom_range(0, 9) < 7) ? vtx_t'(base + $urandom_range(0, 15))
                                           : vtx_t'($urandom_range(0, 255));
        count = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 14);
        fresh = ($urandom_range(0, 11) == 0);
        if (count == 0)
        begin
            send_neighbor(fresh, vtx, vtx_t'($urandom_range(0, 255)), 1'b0, 1'b1);
            return;
        end
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                nbr = vtx;
            end
            else if (r < 80)
            begin
                nbr = vtx_t'(base + $urandom_range(0, 15));
            end
            else
            begin
                nbr = vtx_t'($urandom_range(0, 255));
            end
            ok = ($urandom_range(0, 99) >= 10);
            if ($urandom_range(0, 19) == 0)
            begin
                vtx = vtx_t'($urandom_range(0, 255));
            end
            send_neighbor(fresh, vtx, nbr, ok, k == count - 1);
            fresh = ($urandom_range(0, 59) == 0);
        end
    endtask

    // Random vertices until the item budget is spent. Partway through, the
    // receiver is asked for a long hold-off while the sender floods, so the
    // block fills up and has to drop s_axis_tready.
    task automatic run_random();
        int start;
        bit hold_done;
        start     = items_sent;
        hold_done = 1'b0;
        while (items_sent < start + RANDOM_ITEMS)
        begin
            if (!hold_done && items_sent >= start + 300)
            begin
                hold_request = 1'b1;
                steady_items = 100;
                hold_done    = 1'b1;
            end
            color_random_vertex();
        end
    endtask

    // A complete graph on the lowest CLIQUE_SIZE vertices: vertex v sees
    // vertices 0 to v-1 and gets color v, so the color count climbs steadily.
    // Vertex 0 is then recolored while it sees every clique vertex, itself
    // included, so all lower colors are taken and it moves to the next one up.
    task automatic build_full_clique();
        send_neighbor(1'b1, 8'd0, 8'd0, 1'b0, 1'b1);
        for (int v = 1; v < CLIQUE_SIZE; v++)
        begin
            for (int u = 0; u < v; u++)
            begin
                send_neighbor(1'b0, vtx_t'(v), vtx_t'(u), 1'b1, u == v - 1);
            end
        end
        for (int u = 0; u < CLIQUE_SIZE; u++)
        begin
            send_neighbor(1'b0, 8'd0, vtx_t'(u), 1'b1, u == CLIQUE_SIZE - 1);
        end
    endtask

    // Receiver: random stalls, stretches of steady acceptance, and the long
    // hold-off when the sender side asks for it.
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(30, 120)) @(posedge clk);
            end
            else
            begin
                stall = idle_length();
                if (stall > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // Every result accepted on m_axis is checked against the oldest coloring owed.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            sb.check_result(m_axis_tdata);
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES)
            begin
                $display("FAIL greedy_vertex_coloring");
                $finish;
            end
        end
    end

    initial
    begin
        sb            = new();
        items_sent    = 0;
        steady_items  = 0;
        hold_request  = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random();
        build_full_clique();
        s_axis_tvalid <= 1'b0;

        // Drain the results still owed, then linger a little so that any spurious
        // extra result is caught.
        while (sb.awaited.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("PASS greedy_vertex_coloring");
        end
        else
        begin
            $display("FAIL greedy_vertex_coloring");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/gvc_pkg.sv
hdl/gvc_ram.sv
hdl/gvc_color_map.sv
hdl/greedy_vertex_coloring.sv
bench/greedy_vertex_coloring_test.sv
